>>> hw/rtl/txb_pkg.sv
package txb_pkg;

    // Number of bytes that can wait for a decision.
    localparam int BUF_DEPTH = 6;

    // Fixed code words.
    localparam logic [7:0] ESC_CODE    = 8'h7e;
    localparam logic [1:0] PACK_PREFIX = 2'b00;
    localparam logic [1:0] PAIR_PREFIX = 2'b11;
    localparam logic [2:0] SET_PREFIX  = 3'b100;

    typedef logic [2:0] t_cnt;

    // Encoding rules, in order of preference.
    typedef enum logic [1:0] {
        RULE_PACK6,
        RULE_PAIR,
        RULE_SET,
        RULE_ESC
    } t_rule;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic append;
        logic emit;
        logic drop;
        logic run_last;
        logic block_last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cnt count;
        t_cnt count_left;
        logic dec_last;
        logic slot_free;
    } t_stat;

    // Returns {hit, index} for the 32-character set "a-z A T . , space newline".
    function automatic logic [5:0] set_lookup(input logic [7:0] b);
        logic [7:0] off;
        logic [5:0] res;
        begin
            off = b - 8'h61;
            case (b) inside
                [8'h61:8'h7a]: res = {1'b1, off[4:0]};
                8'h41:         res = {1'b1, 5'd26};
                8'h54:         res = {1'b1, 5'd27};
                8'h2e:         res = {1'b1, 5'd28};
                8'h2c:         res = {1'b1, 5'd29};
                8'h20:         res = {1'b1, 5'd30};
                8'h0a:         res = {1'b1, 5'd31};
                default:       res = 6'd0;
            endcase
            return res;
        end
    endfunction

endpackage

>>> hw/rtl/txb_in_if.sv
interface txb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       blk_end;

    modport source (output valid, output data_byte, output blk_end, input ready);
    modport sink   (input valid, input data_byte, input blk_end, output ready);
endinterface

>>> hw/rtl/txb_out_if.sv
interface txb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       run_last;
    logic       block_last;

    modport source (output valid, output code_byte, output run_last, output block_last,
                    input ready);
    modport sink   (input valid, input code_byte, input run_last, input block_last,
                    output ready);
endinterface

>>> hw/rtl/txb_dpath.sv
module txb_dpath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_data_byte,
    input  txb_pkg::t_cmd i_cmd,
    output txb_pkg::t_stat o_stat,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [7:0]    o_code_byte,
    output logic          o_run_last,
    output logic          o_block_last
);
    import txb_pkg::*;

    logic [7:0] r_buf [BUF_DEPTH];
    logic [7:0] n_buf [BUF_DEPTH];
    t_cnt       r_count, n_count;
    logic [1:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_code, n_code;
    logic       r_run_last, n_run_last;
    logic       r_block_last, n_block_last;

    logic [BUF_DEPTH-1:0] hit;
    logic [4:0]           sx [BUF_DEPTH];
    t_rule                rule;
    logic [7:0]           cand [4];
    logic [1:0]           last_idx;
    t_cnt                 drop_n;
    t_cnt                 count_left;
    t_cnt                 base;

    // Set lookup on every pending byte.
    always_comb begin
        for (int i = 0; i < BUF_DEPTH; i++) begin
            {hit[i], sx[i]} = set_lookup(r_buf[i]);
        end
    end

    // Greedy rule selection on the oldest pending bytes.
    always_comb begin
        if (r_count == t_cnt'(BUF_DEPTH) && (&hit)) begin
            rule = RULE_PACK6;
        end else if (r_count >= 3'd2 && !r_buf[0][7] && !r_buf[1][7]) begin
            rule = RULE_PAIR;
        end else if (hit[0]) begin
            rule = RULE_SET;
        end else begin
            rule = RULE_ESC;
        end
    end

    // Code bytes of the chosen rule, and how many pending bytes it consumes.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            cand[i] = 8'h00;
        end
        case (rule)
            RULE_PACK6: begin
                cand[0]  = {PACK_PREFIX, sx[0], sx[1][4]};
                cand[1]  = {sx[1][3:0], sx[2][4:1]};
                cand[2]  = {sx[2][0], sx[3], sx[4][4:3]};
                cand[3]  = {sx[4][2:0], sx[5]};
                last_idx = 2'd3;
                drop_n   = t_cnt'(BUF_DEPTH);
            end
            RULE_PAIR: begin
                cand[0]  = {PAIR_PREFIX, r_buf[0][6:1]};
                cand[1]  = {r_buf[0][0], r_buf[1][6:0]};
                last_idx = 2'd1;
                drop_n   = 3'd2;
            end
            RULE_SET: begin
                cand[0]  = {SET_PREFIX, sx[0]};
                last_idx = 2'd0;
                drop_n   = 3'd1;
            end
            default: begin
                cand[0]  = ESC_CODE;
                cand[1]  = r_buf[0];
                last_idx = 2'd1;
                drop_n   = 3'd1;
            end
        endcase
    end

    // Status toward the controller.
    always_comb begin
        count_left        = r_count - drop_n;
        o_stat.count      = r_count;
        o_stat.count_left = count_left;
        o_stat.dec_last   = (r_idx == last_idx);
        o_stat.slot_free  = !r_out_valid || i_out_ready;
    end

    // Pending buffer: drop consumed bytes, then append the new byte behind the rest.
    always_comb begin
        n_buf = r_buf;
        if (i_cmd.drop) begin
            case (drop_n)
                3'd1: begin
                    for (int i = 0; i < BUF_DEPTH - 1; i++) begin
                        n_buf[i] = r_buf[i+1];
                    end
                end
                3'd2: begin
                    for (int i = 0; i < BUF_DEPTH - 2; i++) begin
                        n_buf[i] = r_buf[i+2];
                    end
                end
                default: begin
                    n_buf = r_buf;
                end
            endcase
        end
        base = i_cmd.drop ? count_left : r_count;
        if (i_cmd.append) begin
            n_buf[base] = i_data_byte;
        end
        n_count = base + {2'b00, i_cmd.append};
    end

    // Byte index within the current decision.
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.emit) begin
            n_idx = o_stat.dec_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    // Output register: one code byte per beat.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_code       = r_code;
        n_run_last   = r_run_last;
        n_block_last = r_block_last;
        if (i_cmd.emit) begin
            n_out_valid  = 1'b1;
            n_code       = cand[r_idx];
            n_run_last   = i_cmd.run_last;
            n_block_last = i_cmd.block_last;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_buf        <= n_buf;
        r_code       <= n_code;
        r_run_last   <= n_run_last;
        r_block_last <= n_block_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_code_byte  = r_code;
    assign o_run_last   = r_run_last;
    assign o_block_last = r_block_last;

endmodule

>>> hw/rtl/txb_ctrl.sv
module txb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_blk_end,
    output logic           o_in_ready,
    input  txb_pkg::t_stat i_stat,
    output txb_pkg::t_cmd  o_cmd
);
    import txb_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_flush, n_flush;

    logic   final_byte;
    logic   can_emit;
    logic   accept;
    t_cnt   cnt_base;

    // Emission control and the next state.
    always_comb begin
        final_byte = i_stat.dec_last && (!r_flush || i_stat.count_left == 3'd0);
        can_emit   = (r_state == S_EMIT) && i_stat.slot_free;
        o_in_ready = (r_state == S_IDLE) || (can_emit && final_byte);
        accept     = i_in_valid && o_in_ready;
        cnt_base   = (r_state == S_EMIT) ? i_stat.count_left : i_stat.count;

        o_cmd.append     = accept;
        o_cmd.emit       = can_emit;
        o_cmd.drop       = can_emit && i_stat.dec_last;
        o_cmd.run_last   = final_byte;
        o_cmd.block_last = final_byte && r_flush;

        n_state = r_state;
        n_flush = r_flush;
        if (can_emit && final_byte) begin
            n_state = S_IDLE;
            n_flush = 1'b0;
        end
        // A full buffer or a block end starts a decision.
        if (accept && (i_blk_end || cnt_base == t_cnt'(BUF_DEPTH - 1))) begin
            n_state = S_EMIT;
            n_flush = i_blk_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_flush <= 1'b0;
        end else begin
            r_state <= n_state;
            r_flush <= n_flush;
        end
    end

endmodule

>>> hw/rtl/text_base32_packer_unit.sv
// Text base-32 packer. Each input beat carries one text byte and a block-end flag; the
// block holds up to six pending bytes and, when six are pending or the block ends, picks
// the first rule that fits: six set characters into four 00-prefixed bytes, two 7-bit
// bytes into an 11-prefixed pair, one set character into a 100-prefixed byte, or the 0x7e
// escape plus the raw byte. At block end the remainder is flushed and the final code byte
// carries block_last. The output register sends one code byte per cycle while the port is
// ready, and this port sets the pace: a byte that triggers no decision is simply taken,
// a decision sends each code byte it produces (one to four) in turn, and the next input
// is taken in the cycle that sends the last byte of a decision. While a decision is being
// sent, a stall on the output holds the input as well.
module text_base32_packer_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    txb_in_if.sink    i_in,
    txb_out_if.source o_out
);
    import txb_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    txb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_blk_end   (i_in.blk_end),
        .o_in_ready  (in_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    txb_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_data_byte  (i_in.data_byte),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_code_byte  (o_out.code_byte),
        .o_run_last   (o_out.run_last),
        .o_block_last (o_out.block_last)
    );

    assign i_in.ready = in_ready;

`ifndef SYNTHESIS
    // The last byte of a block also closes the run of its input.
    a_block_last_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (!o_out.block_last || o_out.run_last))
        else $error("block_last without run_last");

    // A new byte is taken during emission only on the final byte of the run.
    a_overlap_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.append && cmd.emit) |-> cmd.run_last)
        else $error("input taken in the middle of a run");

    // A byte is never appended to a full buffer.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.append && !cmd.drop) |-> (stat.count < 3'd6))
        else $error("append to a full pending buffer");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import txb_pkg::*;

    // One expected code beat on the output channel.
    typedef struct packed {
        logic [7:0] code_byte;
        logic       run_last;
        logic       block_last;
    } t_code_beat;

    // Tracks the pending text bytes and the code beats they must produce.
    class txb_scoreboard;
        t_code_beat  expected_codes[$];
        logic [7:0]  held_bytes[BUF_DEPTH];
        int unsigned held_count;
        int unsigned errors;
        string       set_chars;

        function new();
            held_count = 0;
            errors     = 0;
            set_chars  = "abcdefghijklmnopqrstuvwxyzAT., \n";
            foreach (held_bytes[i]) held_bytes[i] = 8'h00;
        endfunction

        // Position in the 32-character set, or -1 when the byte is not in it.
        function int charset_index(logic [7:0] b);
            for (int i = 0; i < 32; i++) begin
                if (set_chars[i] == b) return i;
            end
            return -1;
        endfunction

        function void push_code(logic [7:0] c);
            t_code_beat beat;
            beat.code_byte  = c;
            beat.run_last   = 1'b0;
            beat.block_last = 1'b0;
            expected_codes.push_back(beat);
        endfunction

        // Retire the oldest n held bytes.
        function void retire_bytes(int unsigned n);
            for (int i = 0; i < BUF_DEPTH; i++) begin
                held_bytes[i] = (i + n < BUF_DEPTH) ? held_bytes[i + n] : 8'h00;
            end
            held_count -= n;
        endfunction

        // One greedy choice on the oldest held bytes.
        function void encode_step();
            int         idx[BUF_DEPTH];
            logic [4:0] s[BUF_DEPTH];
            bit         all_in_set;
            t_rule      rule;
            all_in_set = (held_count >= BUF_DEPTH);
            for (int i = 0; i < BUF_DEPTH; i++) begin
                idx[i] = charset_index(held_bytes[i]);
                s[i]   = idx[i][4:0];
                if (idx[i] < 0) all_in_set = 0;
            end
            if (all_in_set)
                rule = RULE_PACK6;
            else if (held_count >= 2 && !held_bytes[0][7] && !held_bytes[1][7])
                rule = RULE_PAIR;
            else if (idx[0] >= 0)
                rule = RULE_SET;
            else
                rule = RULE_ESC;
            case (rule)
                RULE_PACK6: begin
                    push_code({PACK_PREFIX, s[0], s[1][4]});
                    push_code({s[1][3:0], s[2][4:1]});
                    push_code({s[2][0], s[3], s[4][4:3]});
                    push_code({s[4][2:0], s[5]});
                    retire_bytes(6);
                end
                RULE_PAIR: begin
                    push_code({PAIR_PREFIX, held_bytes[0][6:1]});
                    push_code({held_bytes[0][0], held_bytes[1][6:0]});
                    retire_bytes(2);
                end
                RULE_SET: begin
                    push_code({SET_PREFIX, s[0]});
                    retire_bytes(1);
                end
                default: begin
                    push_code(ESC_CODE);
                    push_code(held_bytes[0]);
                    retire_bytes(1);
                end
            endcase
        endfunction

        // Called for every accepted input beat.
        function void note_input(logic [7:0] b, logic last_of_block);
            int unsigned before_cnt;
            before_cnt = expected_codes.size();
            held_bytes[held_count] = b;
            held_count++;
            if (last_of_block) begin
                while (held_count > 0) encode_step();
            end else if (held_count == BUF_DEPTH) begin
                encode_step();
            end
            if (expected_codes.size() > before_cnt) begin
                expected_codes[$].run_last   = 1'b1;
                expected_codes[$].block_last = last_of_block;
            end
        endfunction

        // Called for every accepted output beat.
        function void check_result(logic [7:0] c, logic rl, logic bl);
            t_code_beat want;
            if (expected_codes.size() == 0) begin
                $error("code beat %02h with nothing expected", c);
                errors++;
                return;
            end
            want = expected_codes.pop_front();
            if (c !== want.code_byte) begin
                $error("code_byte: expected %02h, got %02h", want.code_byte, c);
                errors++;
            end
            if (rl !== want.run_last) begin
                $error("run_last: expected %0b, got %0b", want.run_last, rl);
                errors++;
            end
            if (bl !== want.block_last) begin
                $error("block_last: expected %0b, got %0b", want.block_last, bl);
                errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 35;
    localparam int DRAIN_WAIT  = 30;

    logic clk;
    logic rst_n;
    bit   no_idle;
    int unsigned cycle_cnt;
    txb_scoreboard sb;

    txb_in_if  in_if ();
    txb_out_if out_if ();

    text_base32_packer_unit dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // 10 ns clock.
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Sink side: random back-pressure, none during the quiet stretch.
    always @(posedge clk) begin
        out_if.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // Record every accepted input beat.
    always @(posedge clk) begin
        if (rst_n && in_if.valid && in_if.ready)
            sb.note_input(in_if.data_byte, in_if.blk_end);
    end

    // Check every accepted output beat.
    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready)
            sb.check_result(out_if.code_byte, out_if.run_last, out_if.block_last);
    end

    // Offer one text byte and hold it until the block takes it.
    task automatic send_text_byte(input logic [7:0] b, input logic last_of_block);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        in_if.blk_end   <= last_of_block;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
    endtask

    // Byte source for one random block, by flavor.
    function automatic logic [7:0] pick_text_byte(int flavor);
        case (flavor)
            0: return (sb.set_chars[$urandom_range(31)]);
            1: return ($urandom_range(3) == 0) ? 8'($urandom_range(128, 255))
                                               : 8'($urandom_range(0, 127));
            2: return ($urandom_range(4) == 0) ? 8'($urandom_range(0, 127))
                                               : 8'($urandom_range(128, 255));
            default: begin
                if ($urandom_range(1)) return (sb.set_chars[$urandom_range(31)]);
                return 8'($urandom_range(255));
            end
        endcase
    endfunction

    initial begin
        int unsigned sent;
        int unsigned len;
        int          flavor;
        sb              = new();
        no_idle         = 0;
        rst_n           <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.data_byte <= 8'h00;
        in_if.blk_end   <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Six set characters pack into four bytes; the block ends on a 7-bit pair.
        send_text_byte("a", 1'b0);
        send_text_byte("z", 1'b0);
        send_text_byte("A", 1'b0);
        send_text_byte("T", 1'b0);
        send_text_byte(".", 1'b0);
        send_text_byte(",", 1'b0);
        send_text_byte(" ", 1'b0);
        send_text_byte(8'h0a, 1'b1);
        // Six high bytes flushed at block end give the longest run of escapes.
        send_text_byte(8'h80, 1'b0);
        send_text_byte(8'hff, 1'b0);
        send_text_byte(8'hc3, 1'b0);
        send_text_byte(8'h9a, 1'b0);
        send_text_byte(8'he1, 1'b0);
        send_text_byte(8'hfe, 1'b1);
        // A set character, an escape, then pairs including zero and the escape code.
        send_text_byte("q", 1'b0);
        send_text_byte(8'hff, 1'b0);
        send_text_byte(8'h00, 1'b0);
        send_text_byte(ESC_CODE, 1'b0);
        send_text_byte(8'h7f, 1'b0);
        send_text_byte(8'h61, 1'b1);
        // One-byte blocks: a non-set byte escapes, a set byte takes one code.
        send_text_byte(8'h00, 1'b1);
        send_text_byte("n", 1'b1);
        // A set character followed by a high byte cannot pair.
        send_text_byte(8'h0a, 1'b0);
        send_text_byte(8'hb0, 1'b1);

        // Random blocks of mostly short length; a quiet stretch without idling.
        sent = 0;
        while (sent < 480) begin
            len    = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 14);
            flavor = $urandom_range(3);
            for (int i = 0; i < len; i++) begin
                no_idle = (sent >= 150 && sent < 260);
                send_text_byte(pick_text_byte(flavor), (i == len - 1));
                sent++;
            end
        end
        no_idle = 0;
        in_if.valid <= 1'b0;

        // Let the last flush drain, then keep watching for stray beats.
        while (sb.expected_codes.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

>>> text_base32_packer_unit.f
hw/rtl/txb_pkg.sv
hw/rtl/txb_in_if.sv
hw/rtl/txb_out_if.sv
hw/rtl/txb_dpath.sv
hw/rtl/txb_ctrl.sv
hw/rtl/text_base32_packer_unit.sv
verif/tb.sv
